### rtl/core/fmcw_ramp_pll_register_calc_defines.svh
// Assertion macros for the FMCW ramp register calculator.
// Included by the top level; needs nothing else.
`ifndef FMCW_RAMP_PLL_REGISTER_CALC_DEFINES_SVH
`define FMCW_RAMP_PLL_REGISTER_CALC_DEFINES_SVH

// same-cycle implication
`define FPRC_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fprc: same-cycle check failed");

// next-cycle implication
`define FPRC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fprc: next-cycle check failed");

`endif

### rtl/core/fprc_pkg.sv
// Shared types and constants of the FMCW ramp register calculator.
// No dependencies.
package fprc_pkg;

   // one sweep request
   typedef struct packed {
      logic [9:0]  start_freq_tens_mhz;
      logic [11:0] bandwidth_mhz;
      logic [19:0] ramp_time_us;
      logic [19:0] ramp_delay_us;
      logic        sweep_shape;
   } req_item_type;

   // one register word out
   typedef struct packed {
      logic [31:0] register_word;
      logic [2:0]  register_index;
      logic        last_word;
   } rsp_item_type;

   // classified job passed from front to back
   typedef struct packed {
      logic [11:0] n_int;
      logic [11:0] frac_hi;
      logic [12:0] frac_lo;
      logic [24:0] dly_cnt;
      logic [11:0] clk1;
      logic [19:0] ramp_t;
      logic [11:0] bw;
      logic        shape;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   localparam int DIV_NUM_W = 34;
   localparam int DIV_DEN_W = 21;
   localparam int DIV_CNT_W = 6;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_cmd_type;

   localparam logic [2:0] REG_R0 = 3'd0;
   localparam logic [2:0] REG_R1 = 3'd1;
   localparam logic [2:0] REG_R2 = 3'd2;
   localparam logic [2:0] REG_R3 = 3'd3;
   localparam logic [2:0] REG_R4 = 3'd4;
   localparam logic [2:0] REG_R5 = 3'd5;
   localparam logic [2:0] REG_R6 = 3'd6;
   localparam logic [2:0] REG_R7 = 3'd7;

   localparam logic [11:0] LIMIT_12 = 12'd4095;
   localparam logic [19:0] LIMIT_20 = 20'd1048575;
   localparam logic [15:0] LIMIT_16 = 16'd65535;

endpackage

### rtl/core/fprc_req_if.sv
// Request channel of the FMCW ramp register calculator.
// Depends on fprc_pkg.
interface fprc_req_if;
   import fprc_pkg::*;
   logic         valid;
   logic         ready;
   req_item_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### rtl/core/fprc_rsp_if.sv
// Result channel of the FMCW ramp register calculator.
// Depends on fprc_pkg.
interface fprc_rsp_if;
   import fprc_pkg::*;
   logic         valid;
   logic         ready;
   rsp_item_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### rtl/core/fprc_front.sv
// Front end: accepts requests and works out N, fraction, delay count and CLK1.
// Depends on fprc_pkg and fprc_req_if.
module fprc_front (
   fprc_req_if.sink            req_chan,
   input  fprc_pkg::queue_status_type q_status,
   output logic                push,
   output fprc_pkg::job_type   push_job
);
   import fprc_pkg::*;

   logic [12:0] s5;
   logic [24:0] frac;
   logic [24:0] cnt;
   logic [25:0] cnt_up;
   logic [13:0] q;
   logic [14:0] r;

   assign req_chan.ready = !q_status.full;
   assign push = req_chan.valid && !q_status.full;

   always_comb begin
      // f / PFD = s*5/16 exactly at 32 MHz
      s5 = {1'b0, req_chan.payload.start_freq_tens_mhz, 2'b00}
         + {3'b000, req_chan.payload.start_freq_tens_mhz};
      frac = {s5[3:0], 21'd0};

      // delay count = 32 per microsecond, at least one
      if (req_chan.payload.ramp_delay_us == 20'd0) begin
         cnt = 25'd1;
      end else begin
         cnt = {req_chan.payload.ramp_delay_us, 5'd0};
      end

      // ceil(cnt / 4095): estimate by >>12, then fix up
      cnt_up = {1'b0, cnt} + 26'd4094;
      q = cnt_up[25:12];
      r = {3'b000, cnt_up[11:0]} + {1'b0, q};
      for (int i = 0; i < 3; i++) begin
         if (r >= 15'd4095) begin
            r = r - 15'd4095;
            q = q + 14'd1;
         end
      end

      push_job.n_int   = {3'b000, s5[12:4]};
      push_job.frac_hi = frac[24:13];
      push_job.frac_lo = frac[12:0];
      push_job.dly_cnt = cnt;
      if (cnt <= 25'd4095) begin
         push_job.clk1 = 12'd1;
      end else if (q > 14'd4095) begin
         push_job.clk1 = LIMIT_12;
      end else begin
         push_job.clk1 = q[11:0];
      end
      push_job.ramp_t = req_chan.payload.ramp_time_us;
      push_job.bw     = req_chan.payload.bandwidth_mhz;
      push_job.shape  = req_chan.payload.sweep_shape;
   end

endmodule

### rtl/core/fprc_queue.sv
// Two-entry job queue between front and back.
// Depends on fprc_pkg.
module fprc_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  fprc_pkg::job_type           push_job,
   input  logic                        pop,
   output fprc_pkg::job_type           pop_job,
   output fprc_pkg::queue_status_type  status
);
   import fprc_pkg::*;

   job_type                mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign pop_job      = mem_ff[rd_ptr_ff];
   assign status.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

### rtl/core/fprc_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on fprc_pkg.
module fprc_div (
   input  logic                               clock,
   input  logic                               reset,
   input  fprc_pkg::div_cmd_type              cmd,
   output logic                               done,
   output logic [fprc_pkg::DIV_NUM_W-1:0]     quot
);
   import fprc_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] step_ff, step_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      trial   = {rem_ff, quo_ff[DIV_NUM_W-1]};
      if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            trial  = trial - {1'b0, den_ff};
            quo_in = {quo_ff[DIV_NUM_W-2:0], 1'b1};
         end else begin
            quo_in = {quo_ff[DIV_NUM_W-2:0], 1'b0};
         end
         rem_in  = trial[DIV_DEN_W-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == DIV_CNT_W'(DIV_NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (cmd.start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = cmd.num;
         rem_in  = '0;
         den_in  = cmd.den;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

### rtl/core/fprc_back.sv
// Back end: runs the three divisions, the offset search, and sends eight words.
// Depends on fprc_pkg, fprc_rsp_if and fprc_div.
module fprc_back (
   input  logic                       clock,
   input  logic                       reset,
   input  fprc_pkg::queue_status_type q_status,
   input  fprc_pkg::job_type          pop_job,
   output logic                       pop,
   fprc_rsp_if.source                 rsp_chan
);
   import fprc_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_DWORD  = 6'b000010,
      ST_STEPS  = 6'b000100,
      ST_OFFSET = 6'b001000,
      ST_DEV    = 6'b010000,
      ST_EMIT   = 6'b100000
   } back_state_type;

   back_state_type state_ff, state_in;
   job_type        job_ff, job_in;
   logic [11:0]    dword_ff, dword_in;
   logic [19:0]    steps_ff, steps_in;
   logic [3:0]     off_ff, off_in;
   logic [15:0]    dev_ff, dev_in;
   logic [2:0]     idx_ff, idx_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_item_type   rsp_item_ff, rsp_item_in;

   div_cmd_type          div_cmd;
   logic                 div_done;
   logic [DIV_NUM_W-1:0] div_quot;

   logic        out_free;
   logic [34:0] bw32;
   logic [3:0]  off_c;
   logic [34:0] den_wide;
   logic [19:0] den_c;
   logic [31:0] word;

   fprc_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .done  (div_done),
      .quot  (div_quot)
   );

   // smallest k with bw*32 <= steps << k, else 15
   always_comb begin
      bw32  = {18'd0, job_ff.bw, 5'd0};
      off_c = 4'd15;
      for (int k = 15; k >= 0; k--) begin
         if (bw32 <= ({15'd0, steps_ff} << k)) begin
            off_c = 4'(k);
         end
      end
      den_wide = {15'd0, steps_ff} << off_c;
      den_c    = den_wide[19:0];
   end

   always_comb begin
      case (idx_ff)
         REG_R7:  word = {13'd0, 4'b1111, dword_ff, REG_R7};
         REG_R6:  word = {9'd0, steps_ff, REG_R6};
         REG_R5:  word = {9'd0, off_ff, dev_ff, REG_R5};
         REG_R4:  word = (32'd3 << 21) | (32'd3 << 19) | (32'd1 << 7) | 32'(REG_R4);
         REG_R3:  word = {21'd0, job_ff.shape, 3'b000, 1'b1, 3'b000, REG_R3};
         REG_R2:  word = {3'b000, 1'b1, 4'd14, 2'b01, 6'd0, 1'b1, job_ff.clk1, REG_R2};
         REG_R1:  word = {4'd0, job_ff.frac_lo, 12'd0, REG_R1};
         REG_R0:  word = {1'b1, 4'd15, job_ff.n_int, job_ff.frac_hi, REG_R0};
         default: word = '0;
      endcase
   end

   always_comb begin
      out_free     = !rsp_valid_ff || rsp_chan.ready;
      state_in     = state_ff;
      job_in       = job_ff;
      dword_in     = dword_ff;
      steps_in     = steps_ff;
      off_in       = off_ff;
      dev_in       = dev_ff;
      idx_in       = idx_ff;
      rsp_item_in  = rsp_item_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      pop          = 1'b0;
      div_cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               pop           = 1'b1;
               job_in        = pop_job;
               div_cmd.start = 1'b1;
               div_cmd.num   = {9'd0, pop_job.dly_cnt};
               div_cmd.den   = {9'd0, pop_job.clk1};
               state_in      = ST_DWORD;
            end
         end
         ST_DWORD: begin
            if (div_done) begin
               if (div_quot == '0) begin
                  dword_in = 12'd1;
               end else if (div_quot > DIV_NUM_W'(LIMIT_12)) begin
                  dword_in = LIMIT_12;
               end else begin
                  dword_in = div_quot[11:0];
               end
               // steps = round(32 * t / clk1)
               div_cmd.start = 1'b1;
               div_cmd.num   = {8'd0, job_ff.ramp_t, 6'd0} + {22'd0, job_ff.clk1};
               div_cmd.den   = {8'd0, job_ff.clk1, 1'b0};
               state_in      = ST_STEPS;
            end
         end
         ST_STEPS: begin
            if (div_done) begin
               if (div_quot == '0) begin
                  steps_in = 20'd1;
               end else if (div_quot > DIV_NUM_W'(LIMIT_20)) begin
                  steps_in = LIMIT_20;
               end else begin
                  steps_in = div_quot[19:0];
               end
               state_in = ST_OFFSET;
            end
         end
         ST_OFFSET: begin
            // dev = round(bw * 2^20 / (steps << off))
            off_in        = off_c;
            div_cmd.start = 1'b1;
            div_cmd.num   = {1'b0, job_ff.bw, 21'd0} + {14'd0, den_c};
            div_cmd.den   = {den_c, 1'b0};
            state_in      = ST_DEV;
         end
         ST_DEV: begin
            if (div_done) begin
               if (div_quot == '0) begin
                  dev_in = 16'd1;
               end else if (div_quot > DIV_NUM_W'(LIMIT_16)) begin
                  dev_in = LIMIT_16;
               end else begin
                  dev_in = div_quot[15:0];
               end
               idx_in   = REG_R7;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in               = 1'b1;
               rsp_item_in.register_word  = word;
               rsp_item_in.register_index = idx_ff;
               rsp_item_in.last_word      = (idx_ff == REG_R0);
               idx_in                     = idx_ff - 3'd1;
               if (idx_ff == REG_R0) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      dword_ff    <= dword_in;
      steps_ff    <= steps_in;
      off_ff      <= off_in;
      dev_ff      <= dev_in;
      idx_ff      <= idx_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_item_ff;

endmodule

### rtl/core/fmcw_ramp_pll_register_calc.sv
// Top level of the FMCW ramp register calculator: front, job queue, back.
// Depends on fprc_pkg, fprc_req_if, fprc_rsp_if, fprc_front, fprc_queue, fprc_back
// and fmcw_ramp_pll_register_calc_defines.svh.
//
//   channel   | dir | handshake         | item
//   ----------+-----+-------------------+--------------------------------------
//   req_chan  | in  | valid/ready       | start freq, bandwidth, ramp, delay, shape
//   rsp_chan  | out | valid/ready       | register word, index, last flag
//
// Each request becomes eight words, R7 first and R0 (last_word set) last.
// Per request, the one shared bit-serial divider runs three 34-step divisions
// (delay word, step count, deviation word), with the offset search between the
// second and third; the eight words then go out.
// Reset is synchronous, active high; it empties the queue and the output register.
// The front keeps accepting into a two-entry queue while the back works; an output
// stall holds the back in its send phase without losing a word.
`include "fmcw_ramp_pll_register_calc_defines.svh"

module fmcw_ramp_pll_register_calc (
   input  logic       clock,
   input  logic       reset,
   fprc_req_if.sink   req_chan,
   fprc_rsp_if.source rsp_chan
);
   import fprc_pkg::*;

   logic             q_push;
   logic             q_pop;
   job_type          q_push_job;
   job_type          q_pop_job;
   queue_status_type q_status;

   // classify: integer N, fraction split, delay count and CLK1
   fprc_front u_front (
      .req_chan (req_chan),
      .q_status (q_status),
      .push     (q_push),
      .push_job (q_push_job)
   );

   // decouples request acceptance from the long back-end computation
   fprc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_push_job),
      .pop      (q_pop),
      .pop_job  (q_pop_job),
      .status   (q_status)
   );

   // divisions, offset search, word assembly and output register
   fprc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .pop_job  (q_pop_job),
      .pop      (q_pop),
      .rsp_chan (rsp_chan)
   );

   // back never pulls from an empty queue
   `FPRC_ASSERT_SAME(a_pop_not_empty, clock, reset, q_pop, !q_status.empty)
   // an accepted item is held in the queue on the next cycle
   `FPRC_ASSERT_NEXT(a_push_lands, clock, reset, q_push, !q_status.empty)
   // last flag goes with R0 only
   `FPRC_ASSERT_SAME(a_last_is_r0, clock, reset, rsp_chan.valid,
      rsp_chan.payload.last_word == (rsp_chan.payload.register_index == REG_R0))
   // words of one request follow without gaps, index counting down
   `FPRC_ASSERT_NEXT(a_index_down, clock, reset,
      rsp_chan.valid && rsp_chan.ready && !rsp_chan.payload.last_word,
      rsp_chan.valid && (rsp_chan.payload.register_index ==
         $past(rsp_chan.payload.register_index) - 3'd1))

endmodule

### test/fprc_tb_if.sv
// Handshake monitor interface of the testbench.
// No dependencies; the channel interfaces come from the RTL.
`timescale 1ns / 1ps
interface fprc_tb_mon_if;
   logic req_fire;
   logic rsp_fire;
endinterface

### test/fmcw_ramp_pll_register_calc_tb.sv
// Testbench of the FMCW ramp register calculator: directed table then random sweeps,
// each word checked against an integer predictor. Depends on fprc_pkg, the channel ifs, fprc_tb_mon_if and the DUT.
`timescale 1ns / 1ps
module fmcw_ramp_pll_register_calc_tb;
   import fprc_pkg::*;

   localparam longint unsigned PFD = 64'd32000000;
   localparam int WDOG_LIMIT = 20000;
   localparam int N_RANDOM = 132;

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #5 clock = ~clock;

   fprc_req_if req_chan ();
   fprc_rsp_if rsp_chan ();
   fprc_tb_mon_if mon ();

   fmcw_ramp_pll_register_calc i_dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan)
   );

   assign mon.req_fire = req_chan.valid & req_chan.ready;
   assign mon.rsp_fire = rsp_chan.valid & rsp_chan.ready;

   rsp_item_type words_due[$];
   int errors = 0;
   bit stim_done = 1'b0;
   bit long_hold = 1'b0;

   // directed row: expected R7 word typed only where obvious, 0 = predictor only
   typedef struct {
      req_item_type item;
      logic [31:0]  r7_word;
   } sweep_row_type;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      errors++;
   endtask

   function automatic longint unsigned round_half_up(longint unsigned num,
                                                     longint unsigned den);
      return (2 * num + den) / (2 * den);
   endfunction

   // Integer model of the synthesizer words for one sweep; appends 8 items R7..R0.
   task automatic predict_registers(input req_item_type rq);
      longint unsigned f, n, rem, frac, cnt, clk1, dword, steps, num, den, dev;
      logic [31:0] w [8];
      int off;
      rsp_item_type r;
      f = longint'(rq.start_freq_tens_mhz) * 64'd10000000;
      n = (f / PFD) & 64'hFFF;
      rem = f % PFD;
      frac = (rem << 25) / PFD;
      // zero delay clamps to one count; long delay splits into CLK1 x word
      cnt = round_half_up(longint'(rq.ramp_delay_us) * PFD, 64'd1000000);
      if (cnt < 1) cnt = 1;
      if (cnt <= 4095) begin
         clk1 = 1;
         dword = cnt;
      end else begin
         clk1 = (cnt + 4094) / 4095;
         if (clk1 > 4095) clk1 = 4095;
         dword = cnt / clk1;
         if (dword < 1) dword = 1;
         if (dword > 4095) dword = 4095;
      end
      steps = round_half_up(longint'(rq.ramp_time_us) * PFD, 64'd1000000 * clk1);
      if (steps < 1) steps = 1;
      if (steps > 1048575) steps = 1048575;
      // offset: smallest k with bw*1e6*2^10 <= steps*PFD*2^k, else 15
      num = longint'(rq.bandwidth_mhz) * 64'd1000000 * 64'd1024;
      den = steps * PFD;
      off = 15;
      for (int k = 0; k <= 15; k++) begin
         if (num <= (den << k)) begin
            off = k;
            break;
         end
      end
      dev = round_half_up((longint'(rq.bandwidth_mhz) * 64'd1000000) << 25, den << off);
      if (dev < 1) dev = 1;
      if (dev > 65535) dev = 65535;
      w[7] = 32'h00078000 | (32'(dword) << 3) | 32'd7;
      w[6] = (32'(steps) << 3) | 32'd6;
      w[5] = (32'(off) << 19) | (32'(dev) << 3) | 32'd5;
      w[4] = (32'd3 << 21) | (32'd3 << 19) | (32'd1 << 7) | 32'd4;
      w[3] = (32'(rq.sweep_shape) << 10) | (32'd1 << 6) | 32'd3;
      w[2] = (32'd1 << 28) | (32'd14 << 24) | (32'd1 << 22) | (32'd1 << 15)
           | (32'(clk1) << 3) | 32'd2;
      w[1] = (32'(frac & 64'h1FFF) << 15) | 32'd1;
      w[0] = (32'd1 << 31) | (32'd15 << 27) | (32'(n) << 15)
           | (32'((frac >> 13) & 64'hFFF) << 3);
      for (int i = 7; i >= 0; i--) begin
         r.register_word = w[i];
         r.register_index = 3'(i);
         r.last_word = (i == 0);
         words_due.push_back(r);
      end
   endtask

   // send one item, holding valid until accepted; expectation added on acceptance
   task automatic send_sweep(input req_item_type rq);
      req_chan.valid <= 1'b1;
      req_chan.payload <= rq;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predict_registers(rq);
   endtask

   function automatic req_item_type random_sweep();
      req_item_type rq;
      rq.start_freq_tens_mhz = 10'($urandom);
      rq.bandwidth_mhz = 12'($urandom);
      rq.sweep_shape = 1'($urandom);
      // mostly short times so step counts stay in range; some full-width
      case ($urandom_range(3))
         0: begin
            rq.ramp_time_us = 20'($urandom);
            rq.ramp_delay_us = 20'($urandom);
         end
         1: begin
            rq.ramp_time_us = 20'($urandom_range(2000));
            rq.ramp_delay_us = 20'($urandom_range(200));
         end
         default: begin
            rq.ramp_time_us = 20'($urandom_range(20000));
            rq.ramp_delay_us = 20'($urandom_range(5000));
         end
      endcase
      return rq;
   endfunction

   // stimulus
   initial begin
      sweep_row_type table_rows[$];
      sweep_row_type row;
      req_item_type rq;
      int burst;
      int gap;
      req_chan.valid = 1'b0;
      req_chan.payload = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // zero request: delay clamps to one count
      row.item = '0;
      row.r7_word = 32'h00078000 | (32'd1 << 3) | 32'd7;
      table_rows.push_back(row);
      row.item = '1; row.r7_word = '0; table_rows.push_back(row);
      // delay just under one-divider limit: 127 us = 4064 counts (4095 needs 127.97 us -> 128 us = 4096)
      row.item = '{10'd0, 12'd0, 20'd1, 20'd127, 1'b0};
      row.r7_word = 32'h00078000 | (32'd4064 << 3) | 32'd7;
      table_rows.push_back(row);
      row.r7_word = '0;
      row.item = '{10'd1023, 12'd4095, 20'd0, 20'd0, 1'b1}; table_rows.push_back(row);
      row.item = '{10'd1023, 12'd4095, 20'd1, 20'd0, 1'b0}; table_rows.push_back(row);
      row.item = '{10'd0, 12'd1, 20'hFFFFF, 20'hFFFFF, 1'b0}; table_rows.push_back(row);
      row.item = '{10'd640, 12'd100, 20'd1000, 20'd128, 1'b0}; table_rows.push_back(row);
      row.item = '{10'd575, 12'd1000, 20'd500, 20'd10, 1'b1}; table_rows.push_back(row);
      row.item = '{10'd3, 12'd4000, 20'd32768, 20'd1000, 1'b1}; table_rows.push_back(row);
      row.item = '{10'd1, 12'd2, 20'd3, 20'd4096, 1'b0}; table_rows.push_back(row);
      row.item = '{10'h2AA, 12'h555, 20'hAAAAA, 20'h55555, 1'b1}; table_rows.push_back(row);
      row.item = '{10'h155, 12'hAAA, 20'h55555, 20'hAAAAA, 1'b0}; table_rows.push_back(row);
      foreach (table_rows[i]) begin
         send_sweep(table_rows[i].item);
         if (table_rows[i].r7_word != '0 &&
             words_due[words_due.size() - 8].register_word != table_rows[i].r7_word)
            report_mismatch("directed R7", words_due[words_due.size() - 8].register_word,
                            table_rows[i].r7_word);
      end
      req_chan.valid <= 1'b0;
      // pause until drained
      while (words_due.size() != 0) @(posedge clock);
      // long receiver hold while the sender keeps offering
      long_hold = 1'b1;
      for (int i = 0; i < 6; i++) send_sweep(random_sweep());
      long_hold = 1'b0;
      for (int i = 0; i < N_RANDOM; ) begin
         burst = $urandom_range(12, 1);
         for (int j = 0; j < burst && i < N_RANDOM; j++, i++) send_sweep(random_sweep());
         gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(150);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_chan.valid <= 1'b0;
      stim_done = 1'b1;
   end

   // receiver: stall pattern, plus long hold when requested
   initial begin
      int hold_cycles;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_chan.ready <= 1'b0;
            for (hold_cycles = 0; hold_cycles < 1500; hold_cycles++) @(posedge clock);
            rsp_chan.ready <= 1'b1;
            while (long_hold) @(posedge clock);
         end else begin
            case ((($urandom_range(15)) >> 2))
               0: rsp_chan.ready <= 1'b0;
               1: rsp_chan.ready <= $urandom_range(1);
               default: rsp_chan.ready <= 1'b1;
            endcase
         end
      end
   end

   // checker
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && mon.rsp_fire) begin
         if (words_due.size() == 0) begin
            report_mismatch("unexpected word", rsp_chan.payload.register_word, '0);
         end else begin
            want = words_due.pop_front();
            if (rsp_chan.payload.register_word !== want.register_word)
               report_mismatch($sformatf("R%0d word", want.register_index),
                               rsp_chan.payload.register_word, want.register_word);
            if (rsp_chan.payload.register_index !== want.register_index)
               report_mismatch("index", 32'(rsp_chan.payload.register_index),
                               32'(want.register_index));
            if (rsp_chan.payload.last_word !== want.last_word)
               report_mismatch("last flag", 32'(rsp_chan.payload.last_word),
                               32'(want.last_word));
         end
      end
   end

   // watchdog and end of run
   initial begin
      int idle;
      idle = 0;
      forever begin
         @(posedge clock);
         if (mon.req_fire || mon.rsp_fire) idle = 0;
         else idle++;
         if (idle >= WDOG_LIMIT) begin
            $display("[fmcw_ramp_pll_register_calc] ERROR");
            $finish;
         end
         if (stim_done && words_due.size() == 0) begin
            repeat (200) @(posedge clock);
            if (errors == 0 && words_due.size() == 0)
               $display("[fmcw_ramp_pll_register_calc] OK");
            else
               $display("[fmcw_ramp_pll_register_calc] ERROR");
            $finish;
         end
      end
   end
endmodule
